/* rtl/core/pcrc_pkg.sv */
// Package for the programmable CRC engine.
// Holds register indexes, field codes and the CRC width helpers; no dependencies.

package pcrc_pkg;

    localparam int MAX_CRC_WIDTH = 32;

    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;

    localparam logic [REG_IDX_W-1:0] REG_POLY_SIZE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_IN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_OUT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INIT_VALUE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POLYNOMIAL  = 3'd4;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_FEED    = 1'b1;

    localparam logic [1:0] SIZE_7  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    localparam logic [1:0] DSIZE_8  = 2'd0;
    localparam logic [1:0] DSIZE_16 = 2'd1;

    localparam logic [1:0] REV_NONE     = 2'd0;
    localparam logic [1:0] REV_BYTE     = 2'd1;
    localparam logic [1:0] REV_HALFWORD = 2'd2;
    localparam logic [1:0] REV_WORD     = 2'd3;

    typedef logic [5:0] width_t;

    function automatic width_t crc_width_f(input logic [1:0] size);
        width_t w;
        case (size)
            SIZE_7:  w = 6'd7;
            SIZE_8:  w = 6'd8;
            SIZE_16: w = 6'd16;
            default: w = 6'd32;
        endcase
        if (w > width_t'(MAX_CRC_WIDTH))
        begin
            w = width_t'(MAX_CRC_WIDTH);
        end
        return w;
    endfunction

    function automatic logic [31:0] width_mask_f(input width_t w);
        logic [32:0] m;
        m = (33'd1 << w) - 33'd1;
        return m[31:0];
    endfunction

endpackage

/* rtl/core/programmable_crc_engine_top.sv */
// Top level of the programmable CRC engine: APB register file and CRC datapath.
// Depends on pcrc_pkg for register indexes, field codes and width helpers.

// Each word is accepted into an input register; from there the whole 8, 16 or
// 32 bit update of the CRC is done combinationally by an unrolled shift-and-XOR
// network that feeds the result register. The block takes one word per cycle
// while the result register is free or being emptied. Its rate is set by the
// loop through the CRC register, which closes combinationally. The
// registers must only be written while no word is in flight.

module programmable_crc_engine_top
    import pcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [31:0]         data,
    input  logic [1:0]          data_size,
    input  logic                end_of_block,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         crc_value,
    output logic                block_done
);

    logic [1:0]           poly_size_reg;
    logic [1:0]           reverse_in_reg;
    logic                 reverse_out_reg;
    logic [31:0]          init_value_reg;
    logic [31:0]          polynomial_reg;
    logic [31:0]          crc_reg;
    logic [31:0]          crc_next;

    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    logic [31:0]          s1_data_reg;
    logic [1:0]           s1_size_reg;
    logic                 s1_eob_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_crc_reg;
    logic [31:0]          out_crc_next;
    logic                 out_eob_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 advance;

    width_t               crc_w;
    logic [31:0]          mask;
    logic [4:0]           top_idx;
    width_t               data_n;
    logic [31:0]          data_masked;
    logic [31:0]          rev8;
    logic [31:0]          rev16;
    logic [31:0]          rev32;
    logic [31:0]          data_rev;
    logic [31:0]          data_aligned;
    logic [31:0]          chain [0:32];
    logic [31:0]          feed_crc;
    logic [31:0]          report;
    logic [31:0]          report_rev;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_size_reg   <= SIZE_32;
            reverse_in_reg  <= REV_NONE;
            reverse_out_reg <= 1'b0;
            init_value_reg  <= 32'hFFFF_FFFF;
            polynomial_reg  <= 32'h04C1_1DB7;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_POLY_SIZE:   poly_size_reg   <= pwdata[1:0];
                REG_REVERSE_IN:  reverse_in_reg  <= pwdata[1:0];
                REG_REVERSE_OUT: reverse_out_reg <= pwdata[0];
                REG_INIT_VALUE:  init_value_reg  <= pwdata;
                REG_POLYNOMIAL:  polynomial_reg  <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_POLY_SIZE:   prdata = {30'd0, poly_size_reg};
            REG_REVERSE_IN:  prdata = {30'd0, reverse_in_reg};
            REG_REVERSE_OUT: prdata = {31'd0, reverse_out_reg};
            REG_INIT_VALUE:  prdata = init_value_reg;
            REG_POLYNOMIAL:  prdata = polynomial_reg;
            default:         prdata = 32'd0;
        endcase
    end

    // The input register moves on whenever the result register is free or
    // being emptied in the same cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= operation;
            s1_data_reg <= data;
            s1_size_reg <= data_size;
            s1_eob_reg  <= end_of_block;
        end
    end

    assign crc_w   = crc_width_f(poly_size_reg);
    assign mask    = width_mask_f(crc_w);
    assign top_idx = 5'(crc_w - 6'd1);

    always_comb
    begin
        case (s1_size_reg)
            DSIZE_8:  data_n = 6'd8;
            DSIZE_16: data_n = 6'd16;
            default:  data_n = 6'd32;
        endcase
    end

    assign data_masked = s1_data_reg & width_mask_f(data_n);

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            rev8[i]  = data_masked[(i / 8) * 8 + 7 - (i % 8)];
            rev16[i] = data_masked[(i / 16) * 16 + 15 - (i % 16)];
            rev32[i] = data_masked[31 - i];
        end
    end

    always_comb
    begin
        case (reverse_in_reg)
            REV_BYTE:     data_rev = rev8;
            REV_HALFWORD: data_rev = (data_n == 6'd8) ? rev8 : rev16;
            REV_WORD:     data_rev = rev32 >> (6'd32 - data_n);
            default:      data_rev = data_masked;
        endcase
    end

    // The first data bit to enter the CRC sits at the top of the aligned word.
    assign data_aligned = data_rev << (6'd32 - data_n);

    always_comb
    begin
        chain[0] = crc_reg & mask;
        for (int i = 0; i < 32; i++)
        begin
            chain[i + 1] = (chain[i] << 1) & mask;
            if (chain[i][top_idx] ^ data_aligned[31 - i])
            begin
                chain[i + 1] = chain[i + 1] ^ (polynomial_reg & mask);
            end
        end
    end

    always_comb
    begin
        case (s1_size_reg)
            DSIZE_8:  feed_crc = chain[8];
            DSIZE_16: feed_crc = chain[16];
            default:  feed_crc = chain[32];
        endcase
    end

    always_comb
    begin
        if (s1_op_reg == OP_RESTART)
        begin
            crc_next = init_value_reg & mask;
        end
        else
        begin
            crc_next = (crc_reg & ~mask) | feed_crc;
        end
    end

    assign report = crc_next & mask;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            report_rev[i] = report[31 - i];
        end
    end

    assign out_crc_next = reverse_out_reg ? (report_rev >> (6'd32 - crc_w)) : report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 32'hFFFF_FFFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                crc_reg <= crc_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_crc_reg <= out_crc_next;
            out_eob_reg <= s1_eob_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign crc_value  = out_crc_reg;
    assign block_done = out_eob_reg;

    a_restart_loads_init: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_op_reg == OP_RESTART) |=>
            crc_reg == ($past(init_value_reg) & $past(mask)))
        else $error("Restart word did not load the masked initial value.");

    a_feed_keeps_upper: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_op_reg == OP_FEED) |=>
            (crc_reg & ~$past(mask)) == ($past(crc_reg) & ~$past(mask)))
        else $error("Data word changed CRC bits above the active width.");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_data_reg)
            && $stable(s1_op_reg) && $stable(s1_size_reg))
        else $error("Pending input word was lost or overwritten.");

endmodule

/* tb/tb_programmable_crc_engine_top.sv */
// Self-checking testbench for programmable_crc_engine_top.
// A clocked driver and monitor run data words and check them against a CRC predictor in this file.
// Depends on pcrc_pkg and the RTL of the engine.
`timescale 1ns / 100ps

module tb_programmable_crc_engine_top;
    import pcrc_pkg::*;

    localparam logic [1:0] DSIZE_32 = 2'd2;
    localparam logic [1:0] DSIZE_RSVD = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic        op;
        logic [31:0] data;
        logic [1:0]  size;
        logic        eob;
    } crc_word_t;

    typedef struct packed {
        logic [31:0] crc;
        logic        done;
    } crc_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = OP_RESTART;
    logic [31:0]        data = '0;
    logic [1:0]         data_size = DSIZE_8;
    logic               end_of_block = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        crc_value;
    logic               block_done;

    logic [1:0]  cfg_poly_size = SIZE_32;
    logic [1:0]  cfg_rev_in = REV_NONE;
    logic        cfg_rev_out = 1'b0;
    logic [31:0] cfg_init = 32'hFFFF_FFFF;
    logic [31:0] cfg_poly = 32'h04C1_1DB7;
    logic [31:0] crc_state = 32'hFFFF_FFFF;

    crc_word_t   word_backlog[$];
    crc_result_t expected_crc_q[$];
    int          crc_errors = 0;
    bit          word_taken = 1'b0;
    int          tx_gap = 0;
    int          tx_calm = 0;
    int          rx_stall = 0;
    int          rx_calm = 0;

    programmable_crc_engine_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .data         (data),
        .data_size    (data_size),
        .end_of_block (end_of_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crc_value    (crc_value),
        .block_done   (block_done)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int crc_bits();
        int w;
        case (cfg_poly_size)
            SIZE_7:  w = 7;
            SIZE_8:  w = 8;
            SIZE_16: w = 16;
            default: w = 32;
        endcase
        if (w > MAX_CRC_WIDTH)
        begin
            w = MAX_CRC_WIDTH;
        end
        return w;
    endfunction

    function automatic logic [31:0] low_ones(input int n);
        logic [32:0] m;
        m = (33'd1 << n) - 33'd1;
        return m[31:0];
    endfunction

    function automatic logic [31:0] flip_units(input logic [31:0] v, input int n,
                                               input int unit);
        logic [31:0] r;
        int          pos;
        int          i;
        r = '0;
        if (unit > n)
        begin
            unit = n;
        end
        for (pos = 0; pos < n; pos += unit)
        begin
            for (i = 0; i < unit; i++)
            begin
                r[pos + unit - 1 - i] = v[pos + i];
            end
        end
        return r;
    endfunction

    function automatic void advance_crc(input logic op, input logic [31:0] din,
                                        input logic [1:0] dsize, input logic eob);
        int          w;
        int          n;
        int          i;
        logic [31:0] mask;
        logic [31:0] d;
        logic [31:0] c;
        logic        fb;
        crc_result_t r;
        w = crc_bits();
        mask = low_ones(w);
        if (op == OP_RESTART)
        begin
            crc_state = cfg_init & mask;
        end
        else
        begin
            case (dsize)
                DSIZE_8:  n = 8;
                DSIZE_16: n = 16;
                default:  n = 32;
            endcase
            d = din & low_ones(n);
            case (cfg_rev_in)
                REV_BYTE:     d = flip_units(d, n, 8);
                REV_HALFWORD: d = flip_units(d, n, 16);
                REV_WORD:     d = flip_units(d, n, 32);
                default:      ;
            endcase
            c = crc_state & mask;
            for (i = n - 1; i >= 0; i--)
            begin
                fb = c[w - 1] ^ d[i];
                c = (c << 1) & mask;
                if (fb)
                begin
                    c = c ^ (cfg_poly & mask);
                end
            end
            crc_state = (crc_state & ~mask) | c;
        end
        c = crc_state & mask;
        if (cfg_rev_out)
        begin
            c = flip_units(c, w, w);
        end
        r.crc = c;
        r.done = eob;
        expected_crc_q.push_back(r);
    endfunction

    function automatic int pick_pause(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_word(input logic op, input logic [31:0] d,
                                       input logic [1:0] sz, input logic eob);
        crc_word_t wd;
        wd.op = op;
        wd.data = d;
        wd.size = sz;
        wd.eob = eob;
        word_backlog.push_back(wd);
    endfunction

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            REG_POLY_SIZE:   cfg_poly_size = value[1:0];
            REG_REVERSE_IN:  cfg_rev_in = value[1:0];
            REG_REVERSE_OUT: cfg_rev_out = value[0];
            REG_INIT_VALUE:  cfg_init = value;
            REG_POLYNOMIAL:  cfg_poly = value;
            default:         ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (word_backlog.size() != 0 || in_valid || expected_crc_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            advance_crc(operation, data, data_size, end_of_block);
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        crc_word_t wd;
        if (rst_n && (!in_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (word_backlog.size() != 0)
            begin
                wd = word_backlog.pop_front();
                operation <= wd.op;
                data <= wd.data;
                data_size <= wd.size;
                end_of_block <= wd.eob;
                in_valid <= 1'b1;
                tx_gap = pick_pause(tx_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall = pick_pause(rx_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        crc_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_crc_q.size() == 0)
            begin
                $error("unexpected result word: crc_value %h, block_done %b",
                       crc_value, block_done);
                crc_errors++;
            end
            else
            begin
                exp_r = expected_crc_q.pop_front();
                if (crc_value !== exp_r.crc)
                begin
                    $error("crc_value: expected %h, actual %h", exp_r.crc, crc_value);
                    crc_errors++;
                end
                if (block_done !== exp_r.done)
                begin
                    $error("block_done: expected %b, actual %b", exp_r.done, block_done);
                    crc_errors++;
                end
            end
        end
    end

    initial
    begin
        int k;
        int feeds;
        int nwords;
        int random_words;
        random_words = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_word(OP_FEED, 32'h0000_0000, DSIZE_8, 1'b0);
        queue_word(OP_FEED, 32'hFFFF_FFFF, DSIZE_8, 1'b0);
        queue_word(OP_FEED, 32'hABCD_FFFF, DSIZE_16, 1'b0);
        queue_word(OP_FEED, 32'hFFFF_FFFF, DSIZE_32, 1'b1);
        queue_word(OP_RESTART, 32'hFFFF_FFFF, DSIZE_RSVD, 1'b1);
        queue_word(OP_FEED, 32'h1234_5678, DSIZE_RSVD, 1'b0);
        queue_word(OP_FEED, 32'h0000_0000, DSIZE_32, 1'b1);
        wait_drained();

        reg_write(REG_POLY_SIZE, {30'd0, SIZE_7});
        reg_write(REG_REVERSE_IN, {30'd0, REV_HALFWORD});
        reg_write(REG_REVERSE_OUT, 32'd1);
        reg_write(REG_INIT_VALUE, 32'h0000_0000);
        reg_write(REG_POLYNOMIAL, 32'h0000_0009);
        queue_word(OP_RESTART, 32'h0000_0000, DSIZE_8, 1'b0);
        queue_word(OP_FEED, 32'h5A5A_5AA5, DSIZE_8, 1'b0);
        queue_word(OP_FEED, 32'h0000_1234, DSIZE_16, 1'b0);
        queue_word(OP_FEED, 32'h8000_0001, DSIZE_32, 1'b1);
        wait_drained();

        reg_write(REG_POLY_SIZE, {30'd0, SIZE_8});
        reg_write(REG_REVERSE_IN, {30'd0, REV_BYTE});
        reg_write(REG_REVERSE_OUT, 32'd0);
        reg_write(REG_INIT_VALUE, 32'hFFFF_FFFF);
        reg_write(REG_POLYNOMIAL, 32'hFFFF_FFFF);
        reg_write(REG_SPARE, 32'h0000_0001);
        queue_word(OP_FEED, 32'h0000_0001, DSIZE_8, 1'b0);
        queue_word(OP_RESTART, 32'h0000_0000, DSIZE_32, 1'b0);
        queue_word(OP_FEED, 32'hF0E1_D2C3, DSIZE_32, 1'b0);
        queue_word(OP_FEED, 32'h0000_8001, DSIZE_16, 1'b1);
        wait_drained();

        reg_write(REG_POLY_SIZE, {30'd0, SIZE_16});
        reg_write(REG_REVERSE_IN, {30'd0, REV_WORD});
        reg_write(REG_REVERSE_OUT, 32'd1);
        reg_write(REG_INIT_VALUE, 32'h0000_FFFF);
        reg_write(REG_POLYNOMIAL, 32'h0000_1021);
        queue_word(OP_FEED, 32'h0000_007E, DSIZE_8, 1'b0);
        queue_word(OP_FEED, 32'hFFFF_FFFF, DSIZE_16, 1'b0);
        queue_word(OP_RESTART, 32'h0000_0000, DSIZE_16, 1'b0);
        queue_word(OP_FEED, 32'h0000_0001, DSIZE_32, 1'b0);
        queue_word(OP_FEED, 32'h8000_0000, DSIZE_32, 1'b1);
        wait_drained();

        reg_write(REG_POLY_SIZE, {30'd0, SIZE_32});
        reg_write(REG_REVERSE_IN, {30'd0, REV_NONE});
        reg_write(REG_INIT_VALUE, 32'h0000_0000);
        reg_write(REG_POLYNOMIAL, 32'h0000_0000);
        queue_word(OP_RESTART, 32'h0000_0000, DSIZE_32, 1'b0);
        queue_word(OP_FEED, 32'hFFFF_FFFF, DSIZE_32, 1'b0);
        queue_word(OP_FEED, 32'h0000_0080, DSIZE_8, 1'b1);
        wait_drained();

        while (random_words < 550)
        begin
            reg_write(REG_POLY_SIZE, {30'($urandom()), 2'($urandom_range(0, 3))});
            reg_write(REG_REVERSE_IN, {30'($urandom()), 2'($urandom_range(0, 3))});
            reg_write(REG_REVERSE_OUT, {31'($urandom()), 1'($urandom_range(0, 1))});
            case ($urandom_range(0, 3))
                0:       reg_write(REG_INIT_VALUE, 32'h0000_0000);
                1:       reg_write(REG_INIT_VALUE, 32'hFFFF_FFFF);
                default: reg_write(REG_INIT_VALUE, $urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       reg_write(REG_POLYNOMIAL, 32'h0000_0000);
                1:       reg_write(REG_POLYNOMIAL, 32'hFFFF_FFFF);
                default: reg_write(REG_POLYNOMIAL, $urandom());
            endcase
            if ($urandom_range(0, 5) == 0)
            begin
                reg_write(REG_SPARE, $urandom());
            end
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    queue_word(OP_RESTART, $urandom(), 2'($urandom_range(0, 3)),
                               $urandom_range(0, 9) == 0);
                    feeds = $urandom_range(1, 10);
                    for (k = 0; k < feeds; k++)
                    begin
                        queue_word(OP_FEED, $urandom(), 2'($urandom_range(0, 3)),
                                   k == feeds - 1);
                    end
                    random_words += feeds + 1;
                end
                else
                begin
                    nwords = $urandom_range(1, 5);
                    repeat (nwords)
                    begin
                        queue_word(1'($urandom_range(0, 1)), $urandom(),
                                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                    end
                    random_words += nwords;
                end
            end
            wait_drained();
        end

        if (crc_errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
